// ===== hdl/btb2_pkg.sv =====
// Shared constants, request codes and record types of the two-bit branch target buffer.
`default_nettype none

package btb2_pkg;

  // Number of table entries, one cell per entry.
  localparam int unsigned ENTRIES = 16;

  // Request codes carried in req_type; the unused code behaves as a lookup.
  localparam logic [1:0] REQ_LOOKUP   = 2'd0;
  localparam logic [1:0] REQ_ALLOCATE = 2'd1;
  localparam logic [1:0] REQ_UPDATE   = 2'd2;

  // Saturation limit of the two-bit counter.
  localparam logic [1:0] CTR_MAX = 2'd3;

  // A request as it arrives on the input channel.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] branch_pc;
    logic [31:0] branch_target;
    logic        branch_taken;
  } req_t;

  // A result as it leaves on the output channel.
  typedef struct packed {
    logic        hit;
    logic [1:0]  counter_state;
    logic        predict_taken;
    logic [31:0] predicted_target;
    logic        alloc_dropped;
  } rsp_t;

  // The record that travels from cell to cell along the chain.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] pc;
    logic [31:0] tgt;
    logic        taken;
    logic        found;
    logic [1:0]  counter;
    logic [31:0] target;
  } token_t;

endpackage

`default_nettype wire

// ===== hdl/btb2_if.sv =====
// Valid/ready channel interfaces for requests and results of the branch target buffer.
`default_nettype none

interface btb2_req_if import btb2_pkg::*;;
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface btb2_rsp_if import btb2_pkg::*;;
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hdl/btb2_cell.sv =====
// One table entry with its compare, allocate and counter logic, and the token register behind it.
`default_nettype none

module btb2_cell import btb2_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         hold_i,
  input  wire         valid_i,
  input  wire token_t tok_i,
  output logic        valid_o,
  output token_t      tok_o
);

  logic        entry_valid_q;
  logic [31:0] entry_address_q;
  logic [31:0] entry_target_q;
  logic [1:0]  entry_counter_q;
  logic [1:0]  counter_upd;
  logic        fire;
  logic        match;
  logic        alloc_here;
  logic        valid_q;
  token_t      tok_d;
  token_t      tok_q;

  // The token is consumed here unless the register behind this cell is held.
  assign fire = valid_i && !hold_i;

  // Entries fill in order, so the first free cell seen by an unmatched allocate is the free slot.
  assign match      = entry_valid_q && (entry_address_q == tok_i.pc) && !tok_i.found;
  assign alloc_here = !entry_valid_q && !tok_i.found && (tok_i.req_type == REQ_ALLOCATE);

  // Saturating step of the stored counter.
  always_comb begin
    counter_upd = entry_counter_q;
    if (tok_i.taken) begin
      if (entry_counter_q != CTR_MAX) begin
        counter_upd = entry_counter_q + 2'd1;
      end
    end else begin
      if (entry_counter_q != 2'd0) begin
        counter_upd = entry_counter_q - 2'd1;
      end
    end
  end

  // Outgoing token: this cell fills in the answer when it holds or takes the address.
  always_comb begin
    tok_d = tok_i;
    if (match) begin
      tok_d.found  = 1'b1;
      tok_d.target = entry_target_q;
      if (tok_i.req_type == REQ_UPDATE) begin
        tok_d.counter = counter_upd;
      end else begin
        tok_d.counter = entry_counter_q;
      end
    end else if (alloc_here) begin
      tok_d.found   = 1'b1;
      tok_d.target  = tok_i.tgt;
      tok_d.counter = 2'd0;
    end
  end

  // Entry valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= 1'b0;
    end else if (fire && alloc_here) begin
      entry_valid_q <= 1'b1;
    end
  end

  // Entry contents.
  always_ff @(posedge clk_i) begin
    if (fire && alloc_here) begin
      entry_address_q <= tok_i.pc;
      entry_target_q  <= tok_i.tgt;
      entry_counter_q <= 2'd0;
    end else if (fire && match && (tok_i.req_type == REQ_UPDATE)) begin
      entry_counter_q <= counter_upd;
    end
  end

  // Token register toward the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!hold_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      tok_q <= tok_d;
    end
  end

  assign valid_o = valid_q;
  assign tok_o   = tok_q;

endmodule

`default_nettype wire

// ===== hdl/branch_target_buffer_two_bit.sv =====
// Top level of the two-bit branch target buffer: a chain of entry cells and the channel control.
//
//   channel | direction | payload
//   --------+-----------+----------------------------------------------------------
//   req_i   | in        | req_type, branch_pc, branch_target, branch_taken
//   rsp_o   | out       | hit, counter_state, predict_taken, predicted_target,
//           |           | alloc_dropped
//
// A request walks the chain one cell per cycle while the output does not stall; a new
// request is taken only once the one before it has reached the register of the last cell.
// The register of the last cell is the output register: the next request enters while
// a result waits, and it waits in front of the last cell until the output is free.
// Reset clears all entry valid bits and all token valid bits at once; no clearing pass.
`default_nettype none

module branch_target_buffer_two_bit import btb2_pkg::*; (
  input  wire             clk_i,
  input  wire             rst_ni,
  btb2_req_if.sink        req_i,
  btb2_rsp_if.source      rsp_o
);

  localparam bit SingleCell = (ENTRIES == 1);

  logic               valid_in  [ENTRIES];
  token_t             tok_in    [ENTRIES];
  logic               valid_out [ENTRIES];
  token_t             tok_out   [ENTRIES];
  logic [ENTRIES-1:0] hold;
  logic               out_stall;
  logic               accept;
  logic               fire_last;
  logic               inflight_q;
  token_t             last;

  // The output register stalls while its result is not taken.
  assign out_stall = valid_out[ENTRIES-1] && !rsp_o.ready;
  assign fire_last = valid_in[ENTRIES-1] && !out_stall;

  assign req_i.ready = !inflight_q && !(SingleCell && out_stall);
  assign accept      = req_i.valid && req_i.ready;

  // Token entering the first cell straight from the request port.
  assign tok_in[0] = '{
    req_type: req_i.payload.req_type,
    pc:       req_i.payload.branch_pc,
    tgt:      req_i.payload.branch_target,
    taken:    req_i.payload.branch_taken,
    found:    1'b0,
    counter:  2'd0,
    target:   req_i.payload.branch_pc
  };
  assign valid_in[0] = accept;

  // Only the last cell and the register in front of it ever hold.
  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      if (gi > 0) begin : g_link
        assign valid_in[gi] = valid_out[gi-1];
        assign tok_in[gi]   = tok_out[gi-1];
      end

      if (gi == ENTRIES - 1) begin : g_hold_last
        assign hold[gi] = out_stall;
      end else if (gi == ENTRIES - 2) begin : g_hold_prev
        assign hold[gi] = out_stall && valid_out[gi];
      end else begin : g_hold_none
        assign hold[gi] = 1'b0;
      end

      btb2_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .hold_i  (hold[gi]),
        .valid_i (valid_in[gi]),
        .tok_i   (tok_in[gi]),
        .valid_o (valid_out[gi]),
        .tok_o   (tok_out[gi])
      );
    end
  endgenerate

  // One request travels the chain at a time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= 1'b0;
    end else if (fire_last) begin
      inflight_q <= 1'b0;
    end else if (accept) begin
      inflight_q <= 1'b1;
    end
  end

  // Result fields from the token held in the last cell.
  assign last = tok_out[ENTRIES-1];

  assign rsp_o.valid                    = valid_out[ENTRIES-1];
  assign rsp_o.payload.hit              = last.found;
  assign rsp_o.payload.counter_state    = last.counter;
  assign rsp_o.payload.predict_taken    = last.counter[1];
  assign rsp_o.payload.predicted_target = last.target;
  assign rsp_o.payload.alloc_dropped    = (last.req_type == REQ_ALLOCATE) && !last.found;

endmodule

`default_nettype wire
